/* rtl/tmm_pkg.sv */
`timescale 1ns / 1ps

package tmm_pkg;

    localparam int MAX_PIXELS_DEF  = 65536;
    localparam int COMP_BITS_DEF   = 24;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int OUT_BITS        = 8;
    localparam int LANES           = 3;

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_FETCH = 2'd1,
        FUNC_BEGIN = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        BK_IDLE = 3'd0,
        BK_PREP = 3'd1,
        BK_MUL  = 3'd2,
        BK_DIV  = 3'd3,
        BK_DONE = 3'd4
    } back_state_t;

    typedef struct packed {
        logic last;
        logic none;
    } flags_t;

endpackage

/* rtl/tonemap_min_max_to_8bit_top.sv */
`timescale 1ns / 1ps

// Min/max tone mapper: load (func 0) writes an RGB pixel into the frame store and
// updates the frame minimum and maximum; fetch (func 1) returns the next stored pixel
// with each component mapped to floor((c - lo) * 255 / (max - lo)), lo being the frame
// minimum when min_to_black is set and zero otherwise; begin (func 2) starts a new
// frame. Each fetch reads the store into a register and waits in a small queue for
// the mapping unit, which maps one pixel at a time (offset, multiply by 255, then an
// 8-step restoring divide on all three components in parallel) and holds its result
// until the output is taken. Loads keep flowing while fewer than QUEUE_DEPTH fetches
// wait. Write min_to_black only while idle.
module tonemap_min_max_to_8bit_top #(
    parameter int MAX_PIXELS     = tmm_pkg::MAX_PIXELS_DEF,
    parameter int COMPONENT_BITS = tmm_pkg::COMP_BITS_DEF,
    parameter int QUEUE_DEPTH    = tmm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic                         cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_func,
    input  logic [COMPONENT_BITS-1:0]    s_red_in,
    input  logic [COMPONENT_BITS-1:0]    s_green_in,
    input  logic [COMPONENT_BITS-1:0]    s_blue_in,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tmm_pkg::OUT_BITS-1:0] m_red_out,
    output logic [tmm_pkg::OUT_BITS-1:0] m_green_out,
    output logic [tmm_pkg::OUT_BITS-1:0] m_blue_out,
    output logic                         m_last_pixel,
    output logic                         m_none_left
);

    localparam int CW = COMPONENT_BITS;
    localparam int DW = tmm_pkg::LANES * CW;
    localparam int FW = $bits(tmm_pkg::flags_t);
    localparam int QW = DW + 2 * CW + FW;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    logic            push_valid;
    logic [DW-1:0]   push_comps;
    logic [CW-1:0]   push_lo;
    logic [CW-1:0]   push_span;
    tmm_pkg::flags_t push_flags;
    logic            head_valid;
    logic [QW-1:0]   head_data;
    logic [LW-1:0]   q_level;
    logic            q_pop;
    tmm_pkg::flags_t head_flags;

    tmm_front #(
        .MAX_PIXELS  (MAX_PIXELS),
        .COMP_BITS   (COMPONENT_BITS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_red_in   (s_red_in),
        .s_green_in (s_green_in),
        .s_blue_in  (s_blue_in),
        .q_level    (q_level),
        .push_valid (push_valid),
        .push_comps (push_comps),
        .push_lo    (push_lo),
        .push_span  (push_span),
        .push_flags (push_flags)
    );

    tmm_queue #(
        .WIDTH       (QW),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push_valid),
        .push_data  ({push_comps, push_lo, push_span, push_flags}),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_data  (head_data),
        .level      (q_level)
    );

    assign head_flags = tmm_pkg::flags_t'(head_data[FW-1:0]);

    tmm_back #(
        .COMP_BITS (COMPONENT_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (head_valid),
        .q_comps      (head_data[QW-1 -: DW]),
        .q_lo         (head_data[FW+2*CW-1 -: CW]),
        .q_span       (head_data[FW+CW-1 -: CW]),
        .q_flags      (head_flags),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red_out    (m_red_out),
        .m_green_out  (m_green_out),
        .m_blue_out   (m_blue_out),
        .m_last_pixel (m_last_pixel),
        .m_none_left  (m_none_left)
    );

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_level <= LW'(QUEUE_DEPTH))
        else $error("queue level above depth");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> (q_level < LW'(QUEUE_DEPTH)) || q_pop)
        else $error("push into full queue");

    a_none_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_none_left) |-> (m_red_out == '0) && (m_green_out == '0)
            && (m_blue_out == '0) && !m_last_pixel)
        else $error("empty fetch carries pixel data");

    a_queued_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> !(head_flags.none && head_flags.last))
        else $error("queued beat both last and empty");

endmodule

/* rtl/tmm_front.sv */
`timescale 1ns / 1ps

module tmm_front #(
    parameter int MAX_PIXELS  = tmm_pkg::MAX_PIXELS_DEF,
    parameter int COMP_BITS   = tmm_pkg::COMP_BITS_DEF,
    parameter int QUEUE_DEPTH = tmm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_we,
    input  logic                                    cfg_wdata,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [1:0]                              s_func,
    input  logic [COMP_BITS-1:0]                    s_red_in,
    input  logic [COMP_BITS-1:0]                    s_green_in,
    input  logic [COMP_BITS-1:0]                    s_blue_in,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]        q_level,
    output logic                                    push_valid,
    output logic [tmm_pkg::LANES*COMP_BITS-1:0]     push_comps,
    output logic [COMP_BITS-1:0]                    push_lo,
    output logic [COMP_BITS-1:0]                    push_span,
    output tmm_pkg::flags_t                         push_flags
);

    localparam int CW   = COMP_BITS;
    localparam int DW   = tmm_pkg::LANES * CW;
    localparam int CNTW = $clog2(MAX_PIXELS + 1);
    localparam int AW   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int LW1  = $clog2(QUEUE_DEPTH + 1) + 1;

    logic [DW-1:0]   store [MAX_PIXELS];

    logic            mtb_reg, mtb_next;
    logic [CW-1:0]   min_reg, min_next;
    logic [CW-1:0]   max_reg, max_next;
    logic [CNTW-1:0] load_cnt_reg, load_cnt_next;
    logic [CNTW-1:0] rd_pos_reg, rd_pos_next;
    logic            pend_valid_reg, pend_valid_next;
    tmm_pkg::flags_t pend_flags_reg, pend_flags_next;
    logic [CW-1:0]   pend_lo_reg, pend_lo_next;
    logic [CW-1:0]   pend_span_reg, pend_span_next;
    logic [DW-1:0]   rd_data_reg;

    logic            accept;
    logic            do_load;
    logic            do_fetch;
    logic            not_full;
    logic [CW-1:0]   mn_rg, mn_rgb, mx_rg, mx_rgb;
    logic [CW-1:0]   lo;
    logic [CW-1:0]   span;
    logic            none;
    logic            last;

    assign s_ready = (LW1'(q_level) + LW1'(pend_valid_reg)) < LW1'(QUEUE_DEPTH);
    assign accept  = s_valid && s_ready;

    assign not_full = load_cnt_reg < CNTW'(MAX_PIXELS);
    assign do_load  = accept && (tmm_pkg::func_t'(s_func) == tmm_pkg::FUNC_LOAD) && not_full;
    assign do_fetch = accept && (tmm_pkg::func_t'(s_func) == tmm_pkg::FUNC_FETCH);

    assign mn_rg  = (s_red_in < s_green_in) ? s_red_in : s_green_in;
    assign mn_rgb = (mn_rg < s_blue_in) ? mn_rg : s_blue_in;
    assign mx_rg  = (s_red_in > s_green_in) ? s_red_in : s_green_in;
    assign mx_rgb = (mx_rg > s_blue_in) ? mx_rg : s_blue_in;

    assign lo   = mtb_reg ? min_reg : '0;
    assign span = (max_reg > lo) ? (max_reg - lo) : '0;
    assign none = !(rd_pos_reg < load_cnt_reg);
    assign last = (CNTW'(rd_pos_reg + CNTW'(1)) == load_cnt_reg);

    always_comb begin
        mtb_next        = mtb_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        load_cnt_next   = load_cnt_reg;
        rd_pos_next     = rd_pos_reg;
        pend_valid_next = do_fetch;
        pend_flags_next = pend_flags_reg;
        pend_lo_next    = pend_lo_reg;
        pend_span_next  = pend_span_reg;
        if (cfg_we) begin
            mtb_next = cfg_wdata;
        end
        if (accept) begin
            case (tmm_pkg::func_t'(s_func))
                tmm_pkg::FUNC_LOAD: begin
                    if (not_full) begin
                        if (mn_rgb < min_reg) begin
                            min_next = mn_rgb;
                        end
                        if (mx_rgb > max_reg) begin
                            max_next = mx_rgb;
                        end
                        load_cnt_next = CNTW'(load_cnt_reg + CNTW'(1));
                    end
                end
                tmm_pkg::FUNC_FETCH: begin
                    pend_flags_next.none = none;
                    pend_flags_next.last = !none && last;
                    pend_lo_next         = lo;
                    pend_span_next       = span;
                    if (!none) begin
                        rd_pos_next = CNTW'(rd_pos_reg + CNTW'(1));
                    end
                end
                tmm_pkg::FUNC_BEGIN: begin
                    min_next      = '1;
                    max_next      = '0;
                    load_cnt_next = '0;
                    rd_pos_next   = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mtb_reg        <= 1'b0;
            min_reg        <= '1;
            max_reg        <= '0;
            load_cnt_reg   <= '0;
            rd_pos_reg     <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            mtb_reg        <= mtb_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            load_cnt_reg   <= load_cnt_next;
            rd_pos_reg     <= rd_pos_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_flags_reg <= pend_flags_next;
        pend_lo_reg    <= pend_lo_next;
        pend_span_reg  <= pend_span_next;
    end

    always_ff @(posedge aclk) begin
        if (do_load) begin
            store[load_cnt_reg[AW-1:0]] <= {s_blue_in, s_green_in, s_red_in};
        end
    end

    always_ff @(posedge aclk) begin
        if (do_fetch) begin
            rd_data_reg <= store[rd_pos_reg[AW-1:0]];
        end
    end

    assign push_valid = pend_valid_reg;
    assign push_comps = rd_data_reg;
    assign push_lo    = pend_lo_reg;
    assign push_span  = pend_span_reg;
    assign push_flags = pend_flags_reg;

endmodule

/* rtl/tmm_queue.sv */
`timescale 1ns / 1ps

module tmm_queue #(
    parameter int WIDTH       = 8,
    parameter int QUEUE_DEPTH = tmm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 push,
    input  logic [WIDTH-1:0]                     push_data,
    input  logic                                 pop,
    output logic                                 head_valid,
    output logic [WIDTH-1:0]                     head_data,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]     level
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0]    level_reg, level_next;
    logic             do_pop;

    assign do_pop     = pop && (level_reg != '0);
    assign head_valid = (level_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign level      = level_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + PW'(1));
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + PW'(1));
        end
        if (push && !do_pop) begin
            level_next = LW'(level_reg + LW'(1));
        end else if (!push && do_pop) begin
            level_next = LW'(level_reg - LW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/tmm_back.sv */
`timescale 1ns / 1ps

module tmm_back #(
    parameter int COMP_BITS = tmm_pkg::COMP_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    input  logic [tmm_pkg::LANES*COMP_BITS-1:0] q_comps,
    input  logic [COMP_BITS-1:0]                q_lo,
    input  logic [COMP_BITS-1:0]                q_span,
    input  tmm_pkg::flags_t                     q_flags,
    output logic                                q_pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tmm_pkg::OUT_BITS-1:0]        m_red_out,
    output logic [tmm_pkg::OUT_BITS-1:0]        m_green_out,
    output logic [tmm_pkg::OUT_BITS-1:0]        m_blue_out,
    output logic                                m_last_pixel,
    output logic                                m_none_left
);

    localparam int CW = COMP_BITS;
    localparam int OB = tmm_pkg::OUT_BITS;
    localparam int NL = tmm_pkg::LANES;
    localparam int NW = CW + OB;
    localparam int SW = $clog2(OB);

    tmm_pkg::back_state_t state_reg, state_next;

    logic [CW-1:0]   comp_reg [NL];
    logic [CW-1:0]   comp_next [NL];
    logic [NW-1:0]   num_reg [NL];
    logic [NW-1:0]   num_next [NL];
    logic [OB-1:0]   quo_reg [NL];
    logic [OB-1:0]   quo_next [NL];
    logic [NL-1:0]   sat_reg, sat_next;
    logic [CW-1:0]   lo_reg, lo_next;
    logic [CW-1:0]   span_reg, span_next;
    tmm_pkg::flags_t flags_reg, flags_next;
    logic [NW-1:0]   den_reg, den_next;
    logic [SW-1:0]   step_reg, step_next;
    logic            m_valid_reg, m_valid_next;
    logic [OB-1:0]   col_reg [NL];
    logic [OB-1:0]   col_next [NL];
    logic            last_reg, last_next;
    logic            none_reg, none_next;

    always_comb begin
        logic [CW-1:0] x;
        logic          slot_free;
        state_next   = state_reg;
        lo_next      = lo_reg;
        span_next    = span_reg;
        flags_next   = flags_reg;
        den_next     = den_reg;
        step_next    = step_reg;
        sat_next     = sat_reg;
        m_valid_next = m_valid_reg && !m_ready;
        last_next    = last_reg;
        none_next    = none_reg;
        q_pop        = 1'b0;
        x            = '0;
        slot_free    = !m_valid_reg || m_ready;
        for (int i = 0; i < NL; i++) begin
            comp_next[i] = comp_reg[i];
            num_next[i]  = num_reg[i];
            quo_next[i]  = quo_reg[i];
            col_next[i]  = col_reg[i];
        end
        case (state_reg)
            tmm_pkg::BK_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    lo_next    = q_lo;
                    span_next  = q_span;
                    flags_next = q_flags;
                    for (int i = 0; i < NL; i++) begin
                        comp_next[i] = q_comps[i*CW +: CW];
                    end
                    state_next = tmm_pkg::BK_PREP;
                end
            end
            tmm_pkg::BK_PREP: begin
                for (int i = 0; i < NL; i++) begin
                    x           = (comp_reg[i] > lo_reg) ? (comp_reg[i] - lo_reg) : '0;
                    num_next[i] = NW'(x);
                    sat_next[i] = (x >= span_reg);
                    quo_next[i] = '0;
                end
                den_next   = NW'(span_reg) << (OB - 1);
                step_next  = '0;
                state_next = tmm_pkg::BK_MUL;
            end
            tmm_pkg::BK_MUL: begin
                for (int i = 0; i < NL; i++) begin
                    num_next[i] = (num_reg[i] << OB) - num_reg[i];
                end
                state_next = tmm_pkg::BK_DIV;
            end
            tmm_pkg::BK_DIV: begin
                for (int i = 0; i < NL; i++) begin
                    if (num_reg[i] >= den_reg) begin
                        num_next[i] = num_reg[i] - den_reg;
                        quo_next[i] = {quo_reg[i][OB-2:0], 1'b1};
                    end else begin
                        quo_next[i] = {quo_reg[i][OB-2:0], 1'b0};
                    end
                end
                den_next  = den_reg >> 1;
                step_next = SW'(step_reg + SW'(1));
                if (step_reg == SW'(OB - 1)) begin
                    state_next = tmm_pkg::BK_DONE;
                end
            end
            tmm_pkg::BK_DONE: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    last_next    = flags_reg.last;
                    none_next    = flags_reg.none;
                    for (int i = 0; i < NL; i++) begin
                        if (flags_reg.none || (span_reg == '0)) begin
                            col_next[i] = '0;
                        end else if (sat_reg[i]) begin
                            col_next[i] = '1;
                        end else begin
                            col_next[i] = quo_reg[i];
                        end
                    end
                    state_next = tmm_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = tmm_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tmm_pkg::BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg    <= lo_next;
        span_reg  <= span_next;
        flags_reg <= flags_next;
        den_reg   <= den_next;
        step_reg  <= step_next;
        sat_reg   <= sat_next;
        last_reg  <= last_next;
        none_reg  <= none_next;
        for (int i = 0; i < NL; i++) begin
            comp_reg[i] <= comp_next[i];
            num_reg[i]  <= num_next[i];
            quo_reg[i]  <= quo_next[i];
            col_reg[i]  <= col_next[i];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_red_out    = col_reg[0];
    assign m_green_out  = col_reg[1];
    assign m_blue_out   = col_reg[2];
    assign m_last_pixel = last_reg;
    assign m_none_left  = none_reg;

endmodule

/* tb/tonemap_min_max_to_8bit_checker.sv */
`timescale 1ns / 1ps

module tonemap_min_max_to_8bit_checker #(
    parameter int MAX_PIXELS     = tmm_pkg::MAX_PIXELS_DEF,
    parameter int COMPONENT_BITS = tmm_pkg::COMP_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic                         cfg_wdata,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [1:0]                   s_func,
    input  logic [COMPONENT_BITS-1:0]    s_red_in,
    input  logic [COMPONENT_BITS-1:0]    s_green_in,
    input  logic [COMPONENT_BITS-1:0]    s_blue_in,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [tmm_pkg::OUT_BITS-1:0] m_red_out,
    input  logic [tmm_pkg::OUT_BITS-1:0] m_green_out,
    input  logic [tmm_pkg::OUT_BITS-1:0] m_blue_out,
    input  logic                         m_last_pixel,
    input  logic                         m_none_left,
    output int                           fail_count,
    output int                           pending,
    output int                           beats_checked,
    output int                           empty_beats
);

    localparam int OUT_BITS = tmm_pkg::OUT_BITS;
    localparam int OUT_FULL = (1 << OUT_BITS) - 1;
    localparam int REPORT_MAX = 10;

    typedef logic [COMPONENT_BITS-1:0] comp_t;
    typedef logic [OUT_BITS-1:0] shade_t;

    typedef struct packed {
        shade_t red;
        shade_t green;
        shade_t blue;
        logic   last;
        logic   none;
    } mapped_pixel_t;

    comp_t frame_red   [MAX_PIXELS];
    comp_t frame_green [MAX_PIXELS];
    comp_t frame_blue  [MAX_PIXELS];
    comp_t darkest;
    comp_t brightest;
    int unsigned pixels_loaded;
    int unsigned next_out;
    logic to_black;
    mapped_pixel_t owed_pixels[$];
    int fails;
    int checked;
    int empties;

    function automatic shade_t rescale(comp_t c, comp_t base, comp_t range);
        logic [63:0] q;
        if (range == '0 || c <= base) return '0;
        q = (64'(c - base) * 64'(OUT_FULL)) / 64'(range);
        return (q > 64'(OUT_FULL)) ? shade_t'(OUT_FULL) : q[OUT_BITS-1:0];
    endfunction

    function automatic void widen_extremes(comp_t c);
        if (c < darkest) darkest = c;
        if (c > brightest) brightest = c;
    endfunction

    function automatic void restart_frame();
        darkest       = '1;
        brightest     = '0;
        pixels_loaded = 0;
        next_out      = 0;
    endfunction

    always @(posedge aclk) begin : watch
        mapped_pixel_t want;
        mapped_pixel_t got;
        comp_t base;
        comp_t range;
        int unsigned p;
        if (!aresetn) begin
            restart_frame();
            to_black = 1'b0;
            owed_pixels.delete();
        end else begin
            if (cfg_we) to_black = cfg_wdata;

            if (m_valid && m_ready) begin
                got = '{m_red_out, m_green_out, m_blue_out, m_last_pixel, m_none_left};
                checked++;
                if (m_none_left === 1'b1) empties++;
                if (owed_pixels.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_MAX)
                        $display({"[%0t] unexpected result beat: ",
                                  "r=%0d g=%0d b=%0d last=%b none=%b"},
                                 $time, got.red, got.green, got.blue, got.last, got.none);
                end else begin
                    want = owed_pixels.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.last !== want.last ||
                        got.none !== want.none) begin
                        fails++;
                        if (fails <= REPORT_MAX)
                            $display({"[%0t] result mismatch: expected r=%0d g=%0d b=%0d ",
                                      "last=%b none=%b, got r=%0d g=%0d b=%0d last=%b none=%b"},
                                     $time, want.red, want.green, want.blue, want.last,
                                     want.none, got.red, got.green, got.blue, got.last,
                                     got.none);
                    end
                end
            end

            if (s_valid && s_ready) begin
                case (s_func)
                    tmm_pkg::FUNC_LOAD: begin
                        if (pixels_loaded < MAX_PIXELS) begin
                            frame_red[pixels_loaded]   = s_red_in;
                            frame_green[pixels_loaded] = s_green_in;
                            frame_blue[pixels_loaded]  = s_blue_in;
                            widen_extremes(s_red_in);
                            widen_extremes(s_green_in);
                            widen_extremes(s_blue_in);
                            pixels_loaded++;
                        end
                    end
                    tmm_pkg::FUNC_FETCH: begin
                        want = '0;
                        if (next_out < pixels_loaded) begin
                            p = next_out;
                            base = to_black ? darkest : '0;
                            range = (brightest > base) ? brightest - base : '0;
                            want.red   = rescale(frame_red[p], base, range);
                            want.green = rescale(frame_green[p], base, range);
                            want.blue  = rescale(frame_blue[p], base, range);
                            want.last  = (p + 1 == pixels_loaded);
                            next_out   = p + 1;
                        end else begin
                            want.none = 1'b1;
                        end
                        owed_pixels.push_back(want);
                    end
                    tmm_pkg::FUNC_BEGIN: restart_frame();
                    default: ;
                endcase
            end
        end
        pending       <= owed_pixels.size();
        fail_count    <= fails;
        beats_checked <= checked;
        empty_beats   <= empties;
    end

endmodule

/* tb/tonemap_min_max_to_8bit_top_tb.sv */
`timescale 1ns / 1ps

module tonemap_min_max_to_8bit_top_tb;

    localparam int COMPONENT_BITS = tmm_pkg::COMP_BITS_DEF;
    localparam int OUT_BITS       = tmm_pkg::OUT_BITS;
    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_CYCLES = 30;
    localparam int IDLE_PCT     = 30;

    typedef logic [COMPONENT_BITS-1:0] comp_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_func = tmm_pkg::FUNC_LOAD;
    comp_t s_red_in = '0;
    comp_t s_green_in = '0;
    comp_t s_blue_in = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [OUT_BITS-1:0] m_red_out;
    logic [OUT_BITS-1:0] m_green_out;
    logic [OUT_BITS-1:0] m_blue_out;
    logic m_last_pixel;
    logic m_none_left;

    int fail_count;
    int pending;
    int beats_checked;
    int empty_beats;

    int s_idle_pct = IDLE_PCT;
    int m_stall_pct = IDLE_PCT;
    int cycles = 0;
    int n_loads = 0;
    int n_fetches = 0;
    int n_begins = 0;
    int n_spare = 0;
    int n_cfg = 0;

    always #5 aclk = ~aclk;

    tonemap_min_max_to_8bit_top u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_red_in     (s_red_in),
        .s_green_in   (s_green_in),
        .s_blue_in    (s_blue_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red_out    (m_red_out),
        .m_green_out  (m_green_out),
        .m_blue_out   (m_blue_out),
        .m_last_pixel (m_last_pixel),
        .m_none_left  (m_none_left)
    );

    tonemap_min_max_to_8bit_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_red_in      (s_red_in),
        .s_green_in    (s_green_in),
        .s_blue_in     (s_blue_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red_out     (m_red_out),
        .m_green_out   (m_green_out),
        .m_blue_out    (m_blue_out),
        .m_last_pixel  (m_last_pixel),
        .m_none_left   (m_none_left),
        .fail_count    (fail_count),
        .pending       (pending),
        .beats_checked (beats_checked),
        .empty_beats   (empty_beats)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= m_stall_pct);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send(input logic [1:0] op, input comp_t r, input comp_t g, input comp_t b);
        logic took;
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_func     <= op;
        s_red_in   <= r;
        s_green_in <= g;
        s_blue_in  <= b;
        took = 1'b0;
        while (!took) begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end
        case (op)
            tmm_pkg::FUNC_LOAD:  n_loads++;
            tmm_pkg::FUNC_FETCH: n_fetches++;
            tmm_pkg::FUNC_BEGIN: n_begins++;
            default:             n_spare++;
        endcase
    endtask

    task automatic send_op(input logic [1:0] op);
        send(op, comp_t'($urandom), comp_t'($urandom), comp_t'($urandom));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic to_black);
        cfg_we    <= 1'b1;
        cfg_wdata <= to_black;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        n_cfg++;
    endtask

    function automatic comp_t styled(int style, comp_t base);
        case (style)
            0: return comp_t'($urandom);
            1: return base + comp_t'($urandom_range(0, 255));
            2: return base;
            default: begin
                case ($urandom_range(2))
                    0: return '0;
                    1: return '1;
                    default: return comp_t'($urandom);
                endcase
            end
        endcase
    endfunction

    task automatic run_directed();
        send_op(tmm_pkg::FUNC_FETCH);
        send_op(FUNC_SPARE);
        send_op(tmm_pkg::FUNC_BEGIN);
        send(tmm_pkg::FUNC_LOAD, '0, '0, '0);
        send(tmm_pkg::FUNC_LOAD, '1, 24'h800000, 24'h000001);
        send(tmm_pkg::FUNC_LOAD, 24'h123456, 24'h000100, 24'hFFFFFE);
        send_op(tmm_pkg::FUNC_FETCH);
        send_op(tmm_pkg::FUNC_FETCH);
        send(tmm_pkg::FUNC_LOAD, 24'h000007, 24'h000007, 24'h000007);
        send_op(tmm_pkg::FUNC_FETCH);
        send_op(tmm_pkg::FUNC_FETCH);
        send_op(tmm_pkg::FUNC_FETCH);
        send_op(tmm_pkg::FUNC_BEGIN);
        send(tmm_pkg::FUNC_LOAD, 24'h000005, 24'h000005, 24'h000005);
        send(tmm_pkg::FUNC_LOAD, 24'h000005, 24'h000005, 24'h000005);
        send_op(tmm_pkg::FUNC_FETCH);
        send_op(tmm_pkg::FUNC_FETCH);
        send_op(tmm_pkg::FUNC_BEGIN);
        send(tmm_pkg::FUNC_LOAD, '0, '0, '0);
        send_op(tmm_pkg::FUNC_FETCH);
        send_op(FUNC_SPARE);
        send_op(tmm_pkg::FUNC_FETCH);
        send_op(tmm_pkg::FUNC_BEGIN);
    endtask

    task automatic run_random(input int target);
        int done;
        int kind;
        int len;
        int style;
        int extra;
        int k;
        logic [1:0] op;
        comp_t base;
        done = 0;
        while (done < target) begin
            kind = $urandom_range(99);
            if (kind < 78) begin
                send_op(tmm_pkg::FUNC_BEGIN);
                len = $urandom_range(1, 16);
                style = $urandom_range(3);
                base = comp_t'($urandom);
                for (k = 0; k < len; k++)
                    send(tmm_pkg::FUNC_LOAD, styled(style, base), styled(style, base),
                         styled(style, base));
                extra = $urandom_range(0, 2);
                for (k = 0; k < len + extra; k++) begin
                    if ($urandom_range(9) == 0) begin
                        send(tmm_pkg::FUNC_LOAD, styled(style, base), styled(style, base),
                             styled(style, base));
                        done++;
                    end
                    send_op(tmm_pkg::FUNC_FETCH);
                end
                done += 1 + 2 * len + extra;
            end else if (kind < 92) begin
                op = 2'($urandom_range(3));
                send_op(op);
                if (op != FUNC_SPARE) done++;
            end else begin
                len = $urandom_range(1, 4);
                op = ($urandom_range(1) == 0) ? tmm_pkg::FUNC_LOAD : tmm_pkg::FUNC_FETCH;
                for (k = 0; k < len; k++) send_op(op);
                done += len;
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_cfg(1'b0);
        run_directed();
        wait_idle();
        write_cfg(1'b1);
        run_directed();

        wait_idle();
        write_cfg(1'b0);
        run_random(500);

        wait_idle();
        write_cfg(1'b1);
        s_idle_pct  = 0;
        m_stall_pct = 0;
        run_random(400);
        s_idle_pct  = IDLE_PCT;
        m_stall_pct = IDLE_PCT;

        wait_idle();
        write_cfg(1'b0);
        run_random(300);

        wait_idle();
        write_cfg(1'b1);
        run_random(350);

        wait_idle();
        $display("Covered %0d loads, %0d fetches, %0d frame starts, %0d spare codes,",
                 n_loads, n_fetches, n_begins, n_spare);
        $display("%0d config writes; checked %0d result beats, %0d with no pixel left.",
                 n_cfg, beats_checked, empty_beats);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
